// File: rtl/gab_pkg.sv
`default_nettype none
package gab_pkg;

  // field widths
  localparam int POS_W   = 24;
  localparam int DIFF_W  = POS_W + 1;
  localparam int MASS_W  = 24;
  localparam int ID_W    = 16;
  localparam int GAIN_W  = 32;
  localparam int MINSQ_W = 16;
  localparam int ACC_W   = 32;
  localparam int ANG_W   = 17;
  localparam int CFG_IDX_W = 2;

  // internal widths
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int D2_W   = SQ_W;
  localparam int PROD_W = GAIN_W + MASS_W;
  localparam int REM_W  = D2_W + 1;
  localparam int CX_W   = 58;
  localparam int CZ_W   = 29;
  localparam int CX_SHIFT = 30;

  // pipeline depth
  localparam int DIV_STEPS   = ACC_W;
  localparam int ANGLE_STEPS = 20;

  // angle constants, degrees Q.7
  localparam int ANGLE_FRAC_SHIFT = 13;
  localparam int ANGLE_HALF_RIGHT = 11520;
  localparam int ANGLE_STRAIGHT   = 23040;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINSQ = 2'd1;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 32'd28665900;
  localparam logic [MINSQ_W-1:0] MINSQ_RST = 16'd7;

  // atan(2^-i) in degrees Q.20
  localparam logic signed [CZ_W-1:0] ATAN_TBL [ANGLE_STEPS] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
    29'sd1876857,  29'sd938658,   29'sd469357,   29'sd234682,  29'sd117342,
    29'sd58671,    29'sd29335,    29'sd14668,    29'sd7334,    29'sd3667,
    29'sd1833,     29'sd917,      29'sd458,      29'sd229,     29'sd115
  };

  // data handed from cell to cell
  typedef struct packed {
    logic                   vld;
    logic [ID_W-1:0]        id;
    logic                   sat;
    logic                   dxneg;
    logic                   dypos;
    logic [D2_W-1:0]        d;
    logic [REM_W-1:0]       r;
    logic [ACC_W-1:0]       lo;
    logic [ACC_W-1:0]       q;
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } gab_cell_t;

endpackage
`default_nettype wire

// File: rtl/gab_front.sv
`default_nettype none
module gab_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic                         in_vld,
  input  wire logic [gab_pkg::POS_W-1:0]    emitter_x,
  input  wire logic [gab_pkg::POS_W-1:0]    emitter_y,
  input  wire logic [gab_pkg::MASS_W-1:0]   emitter_mass,
  input  wire logic [gab_pkg::POS_W-1:0]    body_x,
  input  wire logic [gab_pkg::POS_W-1:0]    body_y,
  input  wire logic [gab_pkg::ID_W-1:0]     body_id,
  input  wire logic [gab_pkg::GAIN_W-1:0]   gain,
  input  wire logic [gab_pkg::MINSQ_W-1:0]  min_sq,
  output gab_pkg::gab_cell_t                cell_o
);
  import gab_pkg::*;

  // stage a: differences
  logic                     a_vld_r;
  logic signed [DIFF_W-1:0] a_dx_r, a_dy_r;
  logic [MASS_W-1:0]        a_mass_r;
  logic [ID_W-1:0]          a_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
    if (adv) begin
      a_dx_r   <= $signed({emitter_x[POS_W-1], emitter_x}) - $signed({body_x[POS_W-1], body_x});
      a_dy_r   <= $signed({emitter_y[POS_W-1], emitter_y}) - $signed({body_y[POS_W-1], body_y});
      a_mass_r <= emitter_mass;
      a_id_r   <= body_id;
    end
  end

  // stage b: magnitudes, squares and numerator
  logic [DIFF_W-1:0] ax_nxt, ay_nxt;
  assign ax_nxt = a_dx_r[DIFF_W-1] ? DIFF_W'(-a_dx_r) : DIFF_W'(a_dx_r);
  assign ay_nxt = a_dy_r[DIFF_W-1] ? DIFF_W'(-a_dy_r) : DIFF_W'(a_dy_r);

  logic              b_vld_r, b_dxneg_r, b_dypos_r;
  logic [DIFF_W-1:0] b_ax_r, b_ay_r;
  logic [SQ_W-1:0]   b_sqx_r, b_sqy_r;
  logic [PROD_W-1:0] b_prod_r;
  logic [ID_W-1:0]   b_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
    if (adv) begin
      b_ax_r    <= ax_nxt;
      b_ay_r    <= ay_nxt;
      b_sqx_r   <= SQ_W'(ax_nxt) * SQ_W'(ax_nxt);
      b_sqy_r   <= SQ_W'(ay_nxt) * SQ_W'(ay_nxt);
      b_prod_r  <= PROD_W'(gain) * PROD_W'(a_mass_r);
      b_dxneg_r <= a_dx_r[DIFF_W-1];
      b_dypos_r <= !a_dy_r[DIFF_W-1] && (a_dy_r != '0);
      b_id_r    <= a_id_r;
    end
  end

  // distance, threshold and first cell input
  logic [D2_W-1:0] d2;
  assign d2 = b_sqx_r + b_sqy_r;

  always_comb begin
    cell_o.vld   = b_vld_r && (d2 >= D2_W'(min_sq));
    cell_o.id    = b_id_r;
    cell_o.sat   = REM_W'(b_prod_r[PROD_W-1:ACC_W]) >= REM_W'(d2);
    cell_o.dxneg = b_dxneg_r;
    cell_o.dypos = b_dypos_r;
    cell_o.d     = d2;
    cell_o.r     = REM_W'(b_prod_r[PROD_W-1:ACC_W]);
    cell_o.lo    = b_prod_r[ACC_W-1:0];
    cell_o.q     = '0;
    cell_o.x     = $signed(CX_W'({b_ay_r, {CX_SHIFT{1'b0}}}));
    cell_o.y     = $signed(CX_W'({b_ax_r, {CX_SHIFT{1'b0}}}));
    cell_o.z     = '0;
  end

endmodule
`default_nettype wire

// File: rtl/gab_cell.sv
`default_nettype none
module gab_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire gab_pkg::gab_cell_t cell_i,
  output gab_pkg::gab_cell_t      cell_o
);
  import gab_pkg::*;

  // table slot for this cell, unused past the last rotation
  localparam int TBL_IDX = (IDX < ANGLE_STEPS) ? IDX : 0;

  gab_cell_t cell_r, cell_nxt;
  logic [REM_W-1:0] trial;
  logic             ge;
  logic signed [CX_W-1:0] xs, ys;

  always_comb begin
    cell_nxt = cell_i;
    // one quotient bit per cell
    trial = {cell_i.r[REM_W-2:0], cell_i.lo[ACC_W-1]};
    ge    = trial >= {1'b0, cell_i.d};
    cell_nxt.r  = ge ? trial - {1'b0, cell_i.d} : trial;
    cell_nxt.lo = {cell_i.lo[ACC_W-2:0], 1'b0};
    cell_nxt.q  = {cell_i.q[ACC_W-2:0], ge};
    // one vectoring rotation in the first cells
    xs = cell_i.x >>> IDX;
    ys = cell_i.y >>> IDX;
    if (IDX < ANGLE_STEPS) begin
      if (!cell_i.y[CX_W-1] && cell_i.y != '0) begin
        cell_nxt.x = cell_i.x + ys;
        cell_nxt.y = cell_i.y - xs;
        cell_nxt.z = cell_i.z + ATAN_TBL[TBL_IDX];
      end else if (cell_i.y[CX_W-1]) begin
        cell_nxt.x = cell_i.x - ys;
        cell_nxt.y = cell_i.y + xs;
        cell_nxt.z = cell_i.z - ATAN_TBL[TBL_IDX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (adv) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule
`default_nettype wire

// File: rtl/gravity_acceleration_bearing_unit.sv
`default_nettype none
// Gravity acceleration and bearing for a stream of emitter-body pairs.
// Input channel in_*: one request per pair (emitter position and mass, body
// position and id), valid/ready. Result channel out_*: target id, unsigned
// Q16.16 acceleration gain*mass/d2 (saturating) and a Q9.7 bearing in degrees.
// A pair whose squared distance is under min_sq_distance yields no result.
// Configuration: cfg_we with cfg_addr 0 (gain) or 1 (min_sq_distance). The
// user must write them only while idle; the block does not enforce it. Other
// indexes are ignored. The pipeline has two front stages, a row of 32 cells
// that each make one quotient bit (the first 20 also do one bearing rotation),
// and the output register. One request is accepted per cycle while it moves.
// The whole row moves together; when the output register holds a result that
// is not taken, in_ready drops and every stage holds.
// Reset empties the pipeline and loads the default register values.
module gravity_acceleration_bearing_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [gab_pkg::POS_W-1:0]     in_emitter_x,
  input  wire logic [gab_pkg::POS_W-1:0]     in_emitter_y,
  input  wire logic [gab_pkg::MASS_W-1:0]    in_emitter_mass,
  input  wire logic [gab_pkg::POS_W-1:0]     in_body_x,
  input  wire logic [gab_pkg::POS_W-1:0]     in_body_y,
  input  wire logic [gab_pkg::ID_W-1:0]      in_body_id,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [gab_pkg::ID_W-1:0]      out_target_id,
  output      logic [gab_pkg::ACC_W-1:0]     out_accel_magnitude,
  output      logic [gab_pkg::ANG_W-1:0]     out_accel_angle,
  input  wire logic                          cfg_we,
  input  wire logic [gab_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [gab_pkg::GAIN_W-1:0]    cfg_wdata
);
  import gab_pkg::*;

  // configuration registers
  logic [GAIN_W-1:0]  gain_r;
  logic [MINSQ_W-1:0] minsq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      minsq_r <= MINSQ_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN:  gain_r  <= cfg_wdata;
        REG_MINSQ: minsq_r <= cfg_wdata[MINSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves when the output register is free
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  gab_cell_t chain [DIV_STEPS+1];

  gab_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_vld       (in_valid),
    .emitter_x    (in_emitter_x),
    .emitter_y    (in_emitter_y),
    .emitter_mass (in_emitter_mass),
    .body_x       (in_body_x),
    .body_y       (in_body_y),
    .body_id      (in_body_id),
    .gain         (gain_r),
    .min_sq       (minsq_r),
    .cell_o       (chain[0])
  );

  // row of divide and rotate cells
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    gab_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // bearing rounding, clamp and quadrant fix
  gab_cell_t              last;
  logic signed [CZ_W-1:0] z_rnd;
  logic [13:0]            t;
  logic signed [17:0]     s, ang;

  assign last = chain[DIV_STEPS];

  always_comb begin
    z_rnd = (last.z + CZ_W'(1 << (ANGLE_FRAC_SHIFT - 1))) >>> ANGLE_FRAC_SHIFT;
    if (z_rnd[CZ_W-1]) begin
      t = '0;
    end else if (z_rnd > CZ_W'(ANGLE_HALF_RIGHT)) begin
      t = 14'(ANGLE_HALF_RIGHT);
    end else begin
      t = z_rnd[13:0];
    end
    s   = last.dxneg ? -$signed({4'b0, t}) : $signed({4'b0, t});
    ang = last.dypos ? 18'(ANGLE_STRAIGHT) - s : s;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.vld;
    end
    if (adv) begin
      out_target_id       <= last.id;
      out_accel_magnitude <= last.sat ? '1 : last.q;
      out_accel_angle     <= ang[ANG_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gab_pkg::*;

  localparam int LATENCY = 35;
  localparam int IDLE_LIMIT = 5000;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 2'd3;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [ACC_W-1:0] accel;
    logic [ANG_W-1:0] angle;
  } pull_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POS_W-1:0] in_emitter_x = '0;
  logic [POS_W-1:0] in_emitter_y = '0;
  logic [MASS_W-1:0] in_emitter_mass = '0;
  logic [POS_W-1:0] in_body_x = '0;
  logic [POS_W-1:0] in_body_y = '0;
  logic [ID_W-1:0] in_body_id = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_target_id;
  logic [ACC_W-1:0] out_accel_magnitude;
  logic [ANG_W-1:0] out_accel_angle;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  // shadow of the block registers
  logic [GAIN_W-1:0] gain_reg = GAIN_RST;
  logic [MINSQ_W-1:0] min_sq_reg = MINSQ_RST;

  pull_t pending_pulls[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int rx_off = 0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;

  gravity_acceleration_bearing_unit dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // pull magnitude and bearing for one pair
  function automatic bit predict_pull(input logic [POS_W-1:0] ex, input logic [POS_W-1:0] ey,
                                      input logic [MASS_W-1:0] m, input logic [POS_W-1:0] bx,
                                      input logic [POS_W-1:0] by, input logic [ID_W-1:0] id,
                                      output pull_t p);
    longint dx, dy, ax, ay, x, y, z, xs, ys, s, ang;
    longint unsigned d2, acc, g, mu;
    dx = longint'($signed(ex)) - longint'($signed(bx));
    dy = longint'($signed(ey)) - longint'($signed(by));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    d2 = ax * ax + ay * ay;
    p.id = id;
    p.accel = '0;
    p.angle = '0;
    if (d2 < min_sq_reg) return 1'b0;
    g = gain_reg;
    mu = m;
    if (d2 == 0) acc = 64'hFFFF_FFFF;
    else acc = (g * mu) / d2;
    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    // vectoring rotations
    x = ay <<< 30;
    y = ax <<< 30;
    z = 0;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(ATAN_TBL[i]);
      end else if (y < 0) begin
        x -= ys;
        y += xs;
        z -= longint'(ATAN_TBL[i]);
      end
    end
    z = (z + (64'sd1 <<< (ANGLE_FRAC_SHIFT - 1))) >>> ANGLE_FRAC_SHIFT;
    if (z < 0) z = 0;
    if (z > ANGLE_HALF_RIGHT) z = ANGLE_HALF_RIGHT;
    s = dx < 0 ? -z : z;
    ang = dy > 0 ? ANGLE_STRAIGHT - s : s;
    p.accel = acc[ACC_W-1:0];
    p.angle = ang[ANG_W-1:0];
    return 1'b1;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result side ready pattern
  always @(posedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      rx_off <= 400;
      out_ready <= 1'b0;
    end else if (rx_off > 0) begin
      rx_off <= rx_off - 1;
      out_ready <= 1'b0;
    end else if (!rx_steady && $urandom_range(99) < 30) begin
      rx_off <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    pull_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pulls.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result id=%h accel=%h angle=%h",
                   out_target_id, out_accel_magnitude, out_accel_angle);
      end else begin
        e = pending_pulls.pop_front();
        if (e.id !== out_target_id || e.accel !== out_accel_magnitude ||
            e.angle !== out_accel_angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp id=%h accel=%h angle=%h got id=%h accel=%h angle=%h",
                     e.id, e.accel, e.angle,
                     out_target_id, out_accel_magnitude, out_accel_angle);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_pair(input logic [POS_W-1:0] ex, input logic [POS_W-1:0] ey,
                           input logic [MASS_W-1:0] m, input logic [POS_W-1:0] bx,
                           input logic [POS_W-1:0] by, input logic [ID_W-1:0] id);
    int gap;
    pull_t p;
    gap = tx_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_emitter_x <= ex;
    in_emitter_y <= ey;
    in_emitter_mass <= m;
    in_body_x <= bx;
    in_body_y <= by;
    in_body_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_pull(ex, ey, m, bx, by, id, p)) pending_pulls.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GAIN) gain_reg = val;
    else if (idx == REG_MINSQ) min_sq_reg = val[MINSQ_W-1:0];
  endtask

  // wait out all results and anything still in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pulls.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // pair with a body near the emitter
  task automatic send_near(input int spread);
    logic [POS_W-1:0] ex, ey;
    int ox, oy;
    ex = POS_W'($urandom);
    ey = POS_W'($urandom);
    ox = $urandom_range(2 * spread) - spread;
    oy = $urandom_range(2 * spread) - spread;
    send_pair(ex, ey, MASS_W'($urandom), ex - POS_W'(ox), ey - POS_W'(oy), ID_W'($urandom));
  endtask

  task automatic send_any();
    send_pair(POS_W'($urandom), POS_W'($urandom), MASS_W'($urandom), POS_W'($urandom),
              POS_W'($urandom), ID_W'($urandom));
  endtask

  task automatic send_mix(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 40) send_near(4);
      else if (r < 75) send_near(300);
      else if (r < 90) send_near(40000);
      else send_any();
    end
  endtask

  // field extremes and quadrants under reset values
  task automatic test_defaults();
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h800000, 24'h800000, 16'hFFFF);
    send_pair(24'h800000, 24'h800000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, 16'h0000);
    send_pair(24'h000100, 24'h000000, 24'h000010, 24'h000000, 24'h000000, 16'h0001);
    send_pair(24'h000000, 24'h000100, 24'h000010, 24'h000000, 24'h000000, 16'h0002);
    send_pair(24'hFFFF00, 24'h000000, 24'h000010, 24'h000000, 24'h000000, 16'h0003);
    send_pair(24'h000000, 24'hFFFF00, 24'h000010, 24'h000000, 24'h000000, 16'h0004);
    send_pair(24'hFFFF80, 24'h000080, 24'h001000, 24'h000000, 24'h000000, 16'h0005);
    send_pair(24'h000080, 24'hFFFF80, 24'h001000, 24'h000000, 24'h000000, 16'h0006);
    // below threshold: d2 of 2, 5 and 5, then a zero distance
    send_pair(24'h000001, 24'h000001, 24'h000100, 24'h000000, 24'h000000, 16'h0007);
    send_pair(24'h000002, 24'h000001, 24'h000100, 24'h000001, 24'h000003, 16'h0008);
    send_pair(24'h000000, 24'h000000, 24'h000100, 24'h000002, 24'h000001, 16'h0009);
    send_pair(24'h123456, 24'h123456, 24'h000100, 24'h123456, 24'h123456, 16'h000A);
    drain();
  endtask

  // zero distance and saturation with no threshold
  task automatic test_zero_distance();
    write_reg(REG_GAIN, 32'hFFFFFFFF);
    write_reg(REG_MINSQ, 32'd0);
    send_pair(24'h000000, 24'h000000, 24'h000001, 24'h000000, 24'h000000, 16'h1000);
    send_pair(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 16'h1001);
    send_pair(24'h000001, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 16'h1002);
    send_pair(24'h000000, 24'h000001, 24'h000000, 24'h000000, 24'h000000, 16'h1003);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'h800000, 24'h800000, 16'h1004);
    drain();
  endtask

  // writes to unused indexes leave both registers alone
  task automatic test_unused_index();
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_MINSQ, 32'h0000FFFF);
    write_reg(REG_SPARE0, 32'hFFFFFFFF);
    write_reg(REG_SPARE1, 32'h00000000);
    send_pair(24'h000100, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 16'h2000);
    send_pair(24'h0000FF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 16'h2001);
    send_pair(24'h000000, 24'h0000FF, 24'hFFFFFF, 24'h000000, 24'h000001, 16'h2002);
    drain();
  endtask

  // long receiver hold while the sender keeps pushing, then a sender pause
  task automatic test_backpressure();
    write_reg(REG_GAIN, GAIN_RST);
    write_reg(REG_MINSQ, GAIN_W'(MINSQ_RST));
    tx_steady = 1'b1;
    hold_asked++;
    send_mix(150);
    tx_steady = 1'b0;
    in_valid <= 1'b0;
    while (pending_pulls.size() != 0) @(posedge clk);
    send_mix(50);
    drain();
  endtask

  // random pairs under several register settings
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_GAIN, GAIN_RST);
          write_reg(REG_MINSQ, GAIN_W'(MINSQ_RST));
        end
        1: begin
          write_reg(REG_GAIN, 32'hFFFFFFFF);
          write_reg(REG_MINSQ, 32'd0);
        end
        2: begin
          write_reg(REG_GAIN, 32'd0);
          write_reg(REG_MINSQ, 32'h0000FFFF);
        end
        default: begin
          write_reg(REG_GAIN, $urandom);
          write_reg(REG_MINSQ, $urandom);
        end
      endcase
      rx_steady = (ph == 3);
      tx_steady = (ph == 3);
      send_mix(300);
      rx_steady = 1'b0;
      tx_steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_zero_distance();
    test_unused_index();
    test_backpressure();
    test_random();
    if (mismatches == 0 && pending_pulls.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
